FILE: sv/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int unsigned HeapUnitsDef   = 4096;
  localparam int unsigned HeaderUnitsDef = 1;

  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned REQ_W    = 13;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_NRD,
    S_NCHK,
    S_PMRG,
    S_SPLIT,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   address;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_free;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ffha_store.sv
// Header store: one-write one-read memory with a reset-defined header at offset 0.
`timescale 1ns / 1ps
`default_nettype none

module ffha_store
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_UNITS   = HeapUnitsDef,
  parameter int unsigned HEADER_UNITS = HeaderUnitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mem_ctl_t                            ctl_i,
  input  wire logic [$clog2(HEAP_UNITS)-1:0]       rd_addr_i,
  input  wire logic [$clog2(HEAP_UNITS)-1:0]       wr_addr_i,
  input  wire logic [$clog2(HEAP_UNITS+1)-1:0]     wr_size_i,
  output logic      [$clog2(HEAP_UNITS+1)-1:0]     rd_size_o,
  output logic                                     rd_free_o
);

  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned SW = $clog2(HEAP_UNITS + 1);
  localparam logic [SW-1:0] InitSize = SW'(HEAP_UNITS - HEADER_UNITS);

  logic [SW:0] mem_q [HEAP_UNITS];
  logic [SW:0] rd_data_q;
  logic [SW:0] hdr0_q;
  logic        rd_is0_q;
  logic [SW:0] hdr_sel;

  // Payload memory, no reset.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= {wr_size_i, ctl_i.wr_free};
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Offset 0 is the only header with a defined reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q   <= {InitSize, 1'b1};
      rd_is0_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en && (wr_addr_i == AW'(0))) begin
        hdr0_q <= {wr_size_i, ctl_i.wr_free};
      end
      if (ctl_i.rd_en) begin
        rd_is0_q <= (rd_addr_i == AW'(0));
      end
    end
  end

  assign hdr_sel   = rd_is0_q ? hdr0_q : rd_data_q;
  assign rd_size_o = hdr_sel[SW:1];
  assign rd_free_o = hdr_sel[0];

endmodule

`default_nettype wire

FILE: sv/ffha_ctrl.sv
// Sequencer and shared adder that walk the block chain.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_UNITS   = HeapUnitsDef,
  parameter int unsigned HEADER_UNITS = HeaderUnitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                command_i,
  input  wire logic [REQ_W-1:0]                    request_size_i,
  input  wire logic [ADDR_W-1:0]                   handle_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output result_t                                  res_o,
  output mem_ctl_t                                 mem_ctl_o,
  output logic      [$clog2(HEAP_UNITS)-1:0]       rd_addr_o,
  output logic      [$clog2(HEAP_UNITS)-1:0]       wr_addr_o,
  output logic      [$clog2(HEAP_UNITS+1)-1:0]     wr_size_o,
  input  wire logic [$clog2(HEAP_UNITS+1)-1:0]     rd_size_i,
  input  wire logic                                rd_free_i
);

  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned SW = $clog2(HEAP_UNITS + 1);
  localparam int unsigned PW = (AW + 2 > REQ_W + 2) ? AW + 2 : REQ_W + 2;
  localparam logic [PW-1:0] Hdr  = PW'(HEADER_UNITS);
  localparam logic [PW-1:0] Heap = PW'(HEAP_UNITS);

  state_e          state_q, state_d;
  cmd_e            cmd_q;
  logic [REQ_W-1:0] req_q;
  logic [PW-1:0]   tgt_q;
  logic [PW-1:0]   pos_q;
  logic [SW-1:0]   sz_q;
  logic [AW-1:0]   prev_q;
  logic [SW-1:0]   prev_size_q;
  logic            prev_free_q;
  logic            have_prev_q;
  result_t         res_q;

  logic [PW-1:0]   size_w, req_w;
  logic [PW-1:0]   add_a, add_b, sum;
  logic [PW-1:0]   pos_hdr, remain;
  logic            fits, split, sum_in, at_tgt;

  assign size_w  = PW'(rd_size_i);
  assign req_w   = PW'(req_q);
  assign fits    = rd_free_i && (size_w >= req_w);
  assign split   = size_w > (req_w + Hdr);
  assign pos_hdr = pos_q + Hdr;
  assign remain  = PW'(sz_q) - req_w - Hdr;
  assign at_tgt  = (pos_q == tgt_q);

  // Shared adder: a + b + header.
  always_comb begin
    case (state_q)
      S_CHK: begin
        add_a = pos_q;
        add_b = size_w;
      end
      S_NCHK: begin
        add_a = PW'(sz_q);
        add_b = size_w;
      end
      S_PMRG: begin
        add_a = PW'(prev_size_q);
        add_b = PW'(sz_q);
      end
      S_SPLIT: begin
        add_a = pos_q;
        add_b = req_w;
      end
      default: begin
        add_a = pos_q;
        add_b = '0;
      end
    endcase
  end

  assign sum    = add_a + add_b + Hdr;
  assign sum_in = sum < Heap;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_ALLOC) begin
            state_d = (request_size_i == '0) ? S_RESP : S_RD;
          end else begin
            state_d = (PW'(handle_i) < Hdr) ? S_RESP : S_RD;
          end
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fits) begin
            state_d = split ? S_SPLIT : S_RESP;
          end else begin
            state_d = sum_in ? S_RD : S_RESP;
          end
        end else if (at_tgt) begin
          if (rd_free_i) begin
            state_d = S_RESP;
          end else begin
            state_d = sum_in ? S_NRD : S_PMRG;
          end
        end else begin
          state_d = sum_in ? S_RD : S_RESP;
        end
      end
      S_NRD:   state_d = S_NCHK;
      S_NCHK:  state_d = S_PMRG;
      S_PMRG:  state_d = S_RESP;
      S_SPLIT: state_d = S_RESP;
      S_RESP:  state_d = res_ready_i ? S_IDLE : S_RESP;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    mem_ctl_o = '0;
    wr_addr_o = pos_q[AW-1:0];
    wr_size_o = rd_size_i;
    unique case (state_q)
      S_RD, S_NRD: mem_ctl_o.rd_en = 1'b1;
      S_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          mem_ctl_o.wr_en = fits;
          wr_size_o       = split ? SW'(req_q) : rd_size_i;
        end else begin
          mem_ctl_o.wr_en   = at_tgt && !rd_free_i && !sum_in;
          mem_ctl_o.wr_free = 1'b1;
        end
      end
      S_NCHK: begin
        mem_ctl_o.wr_en   = 1'b1;
        mem_ctl_o.wr_free = 1'b1;
        wr_addr_o         = tgt_q[AW-1:0];
        wr_size_o         = rd_free_i ? SW'(sum) : sz_q;
      end
      S_PMRG: begin
        mem_ctl_o.wr_en   = have_prev_q && prev_free_q;
        mem_ctl_o.wr_free = 1'b1;
        wr_addr_o         = prev_q;
        wr_size_o         = SW'(sum);
      end
      S_SPLIT: begin
        mem_ctl_o.wr_en   = sum_in;
        mem_ctl_o.wr_free = 1'b1;
        wr_addr_o         = sum[AW-1:0];
        wr_size_o         = SW'(remain);
      end
      default: ;
    endcase
  end

  assign rd_addr_o   = pos_q[AW-1:0];
  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_q       <= cmd_e'(command_i);
          req_q       <= request_size_i;
          tgt_q       <= PW'(handle_i) - Hdr;
          pos_q       <= '0;
          have_prev_q <= 1'b0;
          if ((command_i == CMD_ALLOC) && (request_size_i == '0)) begin
            res_q <= '{status: ST_ZERO, address: '0};
          end else begin
            res_q <= '{status: ST_OK, address: '0};
          end
        end
      end
      S_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (fits) begin
            res_q <= '{status: ST_OK, address: pos_hdr[ADDR_W-1:0]};
            sz_q  <= rd_size_i;
          end else if (sum_in) begin
            pos_q <= sum;
          end else begin
            res_q <= '{status: ST_OOM, address: '0};
          end
        end else begin
          if (at_tgt) begin
            sz_q <= rd_size_i;
          end else begin
            prev_q      <= pos_q[AW-1:0];
            prev_size_q <= rd_size_i;
            prev_free_q <= rd_free_i;
            have_prev_q <= 1'b1;
          end
          if (sum_in) begin
            pos_q <= sum;
          end
        end
      end
      S_NCHK: begin
        if (rd_free_i) begin
          sz_q <= SW'(sum);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, header store, result register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   request  | in_valid_i / in_stall_o | command_i, request_size_i, handle_i
//   result   | out_valid_o / out_stall_i | status_o, address_o
//
// Sequence: an accept step, then for each block header visited on the walk a memory
// read and a check on the registered read data, then a split write when the block
// is split, then the handoff of the result to the output register. Freeing an
// allocated block adds a read and check of its successor when that lies inside the
// bank, and a predecessor merge step, taken whether or not the predecessor is free.
// Zero size and a handle below the header size go straight to the result.
// The walk is bound by the single read port of the header store.
// Reset: only the header at offset 0 is defined (free, whole bank); no
// clearing pass, the block is ready right after reset.
// Stalls: a finished result waits in the output register; the next request is
// accepted while it waits, and the sequencer holds only if a second result
// is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_UNITS   = HeapUnitsDef,
  parameter int unsigned HEADER_UNITS = HeaderUnitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire logic [REQ_W-1:0]    request_size_i,
  input  wire logic [ADDR_W-1:0]   handle_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [ADDR_W-1:0]        address_o
);

  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned SW = $clog2(HEAP_UNITS + 1);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [SW-1:0]    wr_size, rd_size;
  logic             rd_free;
  logic             res_valid, res_ready;
  result_t          res;
  result_t          out_q;
  logic             out_valid_q;

  ffha_ctrl #(
    .HEAP_UNITS   (HEAP_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .request_size_i (request_size_i),
    .handle_i       (handle_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_ctl_o      (mem_ctl),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .wr_size_o      (wr_size),
    .rd_size_i      (rd_size),
    .rd_free_i      (rd_free)
  );

  ffha_store #(
    .HEAP_UNITS   (HEAP_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_size_i (wr_size),
    .rd_size_o (rd_size),
    .rd_free_o (rd_free)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign address_o   = out_q.address;

endmodule

`default_nettype wire
